### design/ccint_pkg.sv
// shared types and constants for the circle intersection block
package ccint_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // status of the queue between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### design/ccint_sqrt.sv
// pipelined integer square root, one result bit per stage
module ccint_sqrt #(
    parameter int RW = 16,
    parameter int PW = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*RW-1:0] in_rad,
    input  logic [PW-1:0]   in_side,
    output logic            out_valid,
    output logic [RW-1:0]   out_root,
    output logic [PW-1:0]   out_side
);

    logic [RW-1:0]   vld_reg;
    logic [2*RW-1:0] rad_reg  [RW];
    logic [RW:0]     rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [PW-1:0]   side_reg [RW];

    for (genvar s = 0; s < RW; s++) begin : g_stage
        logic            vi;
        logic [2*RW-1:0] ri;
        logic [RW:0]     mi;
        logic [RW-1:0]   qi;
        logic [PW-1:0]   si;
        logic [RW+2:0]   t;
        logic [RW+2:0]   trial;
        logic [RW+2:0]   diff;
        logic            ge;
        logic [RW:0]     rem_next;

        if (s == 0) begin : g_first
            assign vi = in_valid;
            assign ri = in_rad;
            assign mi = '0;
            assign qi = '0;
            assign si = in_side;
        end else begin : g_rest
            assign vi = vld_reg[s-1];
            assign ri = rad_reg[s-1];
            assign mi = rem_reg[s-1];
            assign qi = root_reg[s-1];
            assign si = side_reg[s-1];
        end

        assign t        = {mi, ri[2*RW-1 -: 2]};
        assign trial    = {1'b0, qi, 2'b01};
        assign ge       = (t >= trial);
        assign diff     = t - trial;
        assign rem_next = ge ? diff[RW:0] : t[RW:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[s]  <= {ri[2*RW-3:0], 2'b00};
                rem_reg[s]  <= rem_next;
                root_reg[s] <= {qi[RW-2:0], ge};
                side_reg[s] <= si;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

### design/ccint_div.sv
// pipelined restoring divider, one quotient bit per stage
module ccint_div #(
    parameter int DW = 16,
    parameter int QW = 16,
    parameter int PW = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [QW+DW-1:0]   in_num,
    input  logic [DW-1:0]      in_den,
    input  logic [PW-1:0]      in_side,
    output logic               out_valid,
    output logic [QW-1:0]      out_quot,
    output logic [PW-1:0]      out_side
);

    logic [QW-1:0] vld_reg;
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] quot_reg [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [PW-1:0] side_reg [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic          vi;
        logic [DW-1:0] mi;
        logic [QW-1:0] li;
        logic [QW-1:0] qi;
        logic [DW-1:0] di;
        logic [PW-1:0] si;
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (s == 0) begin : g_first
            assign vi = in_valid;
            assign mi = in_num[QW+DW-1:QW];
            assign li = in_num[QW-1:0];
            assign qi = '0;
            assign di = in_den;
            assign si = in_side;
        end else begin : g_rest
            assign vi = vld_reg[s-1];
            assign mi = rem_reg[s-1];
            assign li = low_reg[s-1];
            assign qi = quot_reg[s-1];
            assign di = den_reg[s-1];
            assign si = side_reg[s-1];
        end

        assign t        = {mi, li[QW-1]};
        assign ge       = (t >= {1'b0, di});
        assign diff     = t - {1'b0, di};
        assign rem_next = ge ? diff[DW-1:0] : t[DW-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                low_reg[s]  <= {li[QW-2:0], 1'b0};
                quot_reg[s] <= {qi[QW-2:0], ge};
                den_reg[s]  <= di;
                side_reg[s] <= si;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quot  = quot_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

### design/ccint_queue.sv
// short fifo between the front and back pipelines
module ccint_queue #(
    parameter int WIDTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 pop,
    output logic [WIDTH-1:0]     rdata,
    output ccint_pkg::q_status_t status
);

    logic [WIDTH-1:0]              mem_reg [ccint_pkg::QUEUE_DEPTH];
    logic [ccint_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [ccint_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [ccint_pkg::QUEUE_AW:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata        = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (ccint_pkg::QUEUE_AW+1)'(ccint_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

### design/ccint_front.sv
// front pipeline: centre distance and classification of each circle pair
module ccint_front #(
    parameter int W = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [W-1:0]          x0,
    input  logic [W-1:0]          y0,
    input  logic [W-2:0]          r0,
    input  logic [W-1:0]          x1,
    input  logic [W-1:0]          y1,
    input  logic [W-2:0]          r1,
    input  ccint_pkg::q_status_t  q_status,
    output logic                  push,
    output logic [7*W:0]          entry
);

    typedef struct packed {
        logic [W:0]   dy;
        logic [W:0]   dx;
        logic [W-2:0] r1;
        logic [W-2:0] r0;
        logic [W-1:0] y0;
        logic [W-1:0] x0;
    } side_t;

    logic en;
    assign en      = !q_status.full;
    assign s_ready = en;

    // stage 1: differences
    logic  v1_reg;
    side_t s1_reg;
    // stage 2: squares
    logic          v2_reg;
    side_t         s2_reg;
    logic [2*W+1:0] sqx_reg, sqy_reg;
    // stage 3: sum of squares
    logic          v3_reg;
    side_t         s3_reg;
    logic [2*W+1:0] sum2_reg;
    // sqrt output
    logic          vq;
    logic [W:0]    dq;
    side_t         sq;
    // stage 4: classify
    logic          v4_reg;
    side_t         s4_reg;
    logic [W-1:0]  d4_reg;
    logic          found4_reg;

    side_t      s1_next;
    logic [W:0] mdx, mdy;
    logic [W-2:0] rdiff;
    logic [W-1:0] rsum;
    logic       found_next;

    always_comb begin
        s1_next.x0 = x0;
        s1_next.y0 = y0;
        s1_next.r0 = r0;
        s1_next.r1 = r1;
        s1_next.dx = {x1[W-1], x1} - {x0[W-1], x0};
        s1_next.dy = {y1[W-1], y1} - {y0[W-1], y0};
    end

    assign mdx = s1_reg.dx[W] ? (~s1_reg.dx + 1'b1) : s1_reg.dx;
    assign mdy = s1_reg.dy[W] ? (~s1_reg.dy + 1'b1) : s1_reg.dy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= vq;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg   <= s1_next;
            s2_reg   <= s1_reg;
            sqx_reg  <= mdx * mdx;
            sqy_reg  <= mdy * mdy;
            s3_reg   <= s2_reg;
            sum2_reg <= sqx_reg + sqy_reg;
            s4_reg   <= sq;
            d4_reg   <= found_next ? dq[W-1:0] : '0;
            found4_reg <= found_next;
        end
    end

    ccint_sqrt #(.RW(W+1), .PW($bits(side_t))) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v3_reg),
        .in_rad   (sum2_reg),
        .in_side  (s3_reg),
        .out_valid(vq),
        .out_root (dq),
        .out_side (sq)
    );

    assign rdiff = (sq.r0 > sq.r1) ? (sq.r0 - sq.r1) : (sq.r1 - sq.r0);
    assign rsum  = {1'b0, sq.r0} + {1'b0, sq.r1};
    assign found_next = (dq != '0) && (dq >= {2'b00, rdiff}) && (dq <= {1'b0, rsum});

    assign push  = en && v4_reg;
    assign entry = {found4_reg, d4_reg, s4_reg};

endmodule

### design/ccint_back.sv
// back pipeline: base point, half chord and the two crossing points
module ccint_back #(
    parameter int W = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ccint_pkg::q_status_t q_status,
    input  logic [7*W:0]         entry,
    output logic                 pop,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 found,
    output logic [W-1:0]         p1x,
    output logic [W-1:0]         p1y,
    output logic [W-1:0]         p2x,
    output logic [W-1:0]         p2y
);

    typedef struct packed {
        logic         found;
        logic [W-1:0] d;
        logic [W:0]   dy;
        logic [W:0]   dx;
        logic [W-2:0] r1;
        logic [W-2:0] r0;
        logic [W-1:0] y0;
        logic [W-1:0] x0;
    } entry_t;

    typedef struct packed {
        logic [2*W-3:0] rr;
        logic           aneg;
        logic           found;
        logic [W-1:0]   d;
        logic [W:0]     dy;
        logic [W:0]     dx;
        logic [W-1:0]   y0;
        logic [W-1:0]   x0;
    } side_a_t;

    typedef struct packed {
        logic [W-2:0] amag;
        logic         aneg;
        logic         found;
        logic [W-1:0] d;
        logic [W:0]   dy;
        logic [W:0]   dx;
        logic [W-1:0] y0;
        logic [W-1:0] x0;
    } side_h_t;

    typedef struct packed {
        logic         aneg;
        logic         found;
        logic         sdy;
        logic         sdx;
        logic [W-1:0] y0;
        logic [W-1:0] x0;
    } side_q_t;

    function automatic logic [W-1:0] sat(input logic [W+2:0] v);
        logic [W-1:0] r;
        if ((v[W+2:W-1] == '0) || (v[W+2:W-1] == '1)) begin
            r = v[W-1:0];
        end else if (v[W+2]) begin
            r = {1'b1, {(W-1){1'b0}}};
        end else begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    logic   en;
    entry_t e;
    assign en  = !m_valid || m_ready;
    assign pop = en && !q_status.empty;
    assign e   = entry;

    // b1: squares of radii and distance
    logic           v1_reg;
    entry_t         e1_reg;
    logic [2*W-3:0] rr1_reg, qq1_reg;
    logic [2*W-1:0] dd1_reg;
    // b2: numerator of a
    logic           v2_reg;
    side_a_t        sa2_reg;
    logic [2*W-1:0] num2_reg;
    logic [W:0]     den2_reg;
    // b3: a squared
    logic           v3_reg;
    side_h_t        sh3_reg;
    logic [2*W-3:0] rr3_reg;
    logic [2*W-3:0] aa3_reg;
    // b4: radicand of h
    logic           v4_reg;
    side_h_t        sh4_reg;
    logic [2*W-3:0] rad4_reg;
    // b5: products for the scaled offsets
    logic           v5_reg;
    side_q_t        sq5_reg;
    logic [W-1:0]   d5_reg;
    logic [2*W-2:0] pax5_reg, pay5_reg, phx5_reg, phy5_reg;
    // b7: base point and chord offsets
    logic           v7_reg;
    logic           found7_reg;
    logic [W+1:0]   px7_reg, py7_reg;
    logic [W:0]     ex7_reg, ey7_reg;
    // output register
    logic           v8_reg;
    logic           found8_reg;
    logic [W-1:0]   p1x_reg, p1y_reg, p2x_reg, p2y_reg;

    logic [2*W:0]   p_sum, q_ext;
    logic           aneg_next;
    logic [2*W:0]   num_next;
    side_a_t        sa_next;
    logic           va;
    logic [W-2:0]   amag_q;
    side_a_t        sa_q;
    logic           vh;
    logic [W-2:0]   h_q;
    side_h_t        sh_q;
    logic [W:0]     mdx, mdy;
    logic           vd;
    logic [W-1:0]   qax, qay, qex, qey;
    side_q_t        sd_q;
    logic [W:0]     sax, say, sex, sey;
    logic [W+2:0]   o1x, o1y, o2x, o2y;

    assign p_sum     = {3'b000, rr1_reg} + {1'b0, dd1_reg};
    assign q_ext     = {3'b000, qq1_reg};
    assign aneg_next = (p_sum < q_ext);
    assign num_next  = aneg_next ? (q_ext - p_sum) : (p_sum - q_ext);

    always_comb begin
        sa_next.rr    = rr1_reg;
        sa_next.aneg  = aneg_next;
        sa_next.found = e1_reg.found;
        sa_next.d     = e1_reg.d;
        sa_next.dy    = e1_reg.dy;
        sa_next.dx    = e1_reg.dx;
        sa_next.y0    = e1_reg.y0;
        sa_next.x0    = e1_reg.x0;
    end

    assign mdx = sh_q.dx[W] ? (~sh_q.dx + 1'b1) : sh_q.dx;
    assign mdy = sh_q.dy[W] ? (~sh_q.dy + 1'b1) : sh_q.dy;

    // signed offsets from the truncated magnitudes
    assign sax = (sd_q.aneg ^ sd_q.sdx) ? (~{1'b0, qax} + 1'b1) : {1'b0, qax};
    assign say = (sd_q.aneg ^ sd_q.sdy) ? (~{1'b0, qay} + 1'b1) : {1'b0, qay};
    assign sex = sd_q.sdy ? (~{1'b0, qex} + 1'b1) : {1'b0, qex};
    assign sey = sd_q.sdx ? (~{1'b0, qey} + 1'b1) : {1'b0, qey};

    assign o1x = {px7_reg[W+1], px7_reg} + {{2{ex7_reg[W]}}, ex7_reg};
    assign o1y = {py7_reg[W+1], py7_reg} - {{2{ey7_reg[W]}}, ey7_reg};
    assign o2x = {px7_reg[W+1], px7_reg} - {{2{ex7_reg[W]}}, ex7_reg};
    assign o2y = {py7_reg[W+1], py7_reg} + {{2{ey7_reg[W]}}, ey7_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= pop;
            v2_reg <= v1_reg;
            v3_reg <= va;
            v4_reg <= v3_reg;
            v5_reg <= vh;
            v7_reg <= vd;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg   <= e;
            rr1_reg  <= e.r0 * e.r0;
            qq1_reg  <= e.r1 * e.r1;
            dd1_reg  <= e.d * e.d;

            sa2_reg  <= sa_next;
            num2_reg <= num_next[2*W-1:0];
            den2_reg <= {e1_reg.d, 1'b0};

            sh3_reg.amag  <= amag_q;
            sh3_reg.aneg  <= sa_q.aneg;
            sh3_reg.found <= sa_q.found;
            sh3_reg.d     <= sa_q.d;
            sh3_reg.dy    <= sa_q.dy;
            sh3_reg.dx    <= sa_q.dx;
            sh3_reg.y0    <= sa_q.y0;
            sh3_reg.x0    <= sa_q.x0;
            rr3_reg       <= sa_q.rr;
            aa3_reg       <= amag_q * amag_q;

            sh4_reg  <= sh3_reg;
            rad4_reg <= (rr3_reg >= aa3_reg) ? (rr3_reg - aa3_reg) : '0;

            sq5_reg.aneg  <= sh_q.aneg;
            sq5_reg.found <= sh_q.found;
            sq5_reg.sdy   <= sh_q.dy[W];
            sq5_reg.sdx   <= sh_q.dx[W];
            sq5_reg.y0    <= sh_q.y0;
            sq5_reg.x0    <= sh_q.x0;
            d5_reg        <= sh_q.d;
            pax5_reg      <= sh_q.amag * mdx[W-1:0];
            pay5_reg      <= sh_q.amag * mdy[W-1:0];
            phx5_reg      <= h_q * mdx[W-1:0];
            phy5_reg      <= h_q * mdy[W-1:0];

            found7_reg <= sd_q.found;
            px7_reg    <= {{2{sd_q.x0[W-1]}}, sd_q.x0} + {sax[W], sax};
            py7_reg    <= {{2{sd_q.y0[W-1]}}, sd_q.y0} + {say[W], say};
            ex7_reg    <= sex;
            ey7_reg    <= sey;

            found8_reg <= found7_reg;
            p1x_reg    <= found7_reg ? sat(o1x) : '0;
            p1y_reg    <= found7_reg ? sat(o1y) : '0;
            p2x_reg    <= found7_reg ? sat(o2x) : '0;
            p2y_reg    <= found7_reg ? sat(o2y) : '0;
        end
    end

    // a = (r0^2 - r1^2 + d^2) / 2d
    ccint_div #(.DW(W+1), .QW(W-1), .PW($bits(side_a_t))) u_div_a (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v2_reg), .in_num(num2_reg), .in_den(den2_reg), .in_side(sa2_reg),
        .out_valid(va), .out_quot(amag_q), .out_side(sa_q)
    );

    // h = sqrt(r0^2 - a^2)
    ccint_sqrt #(.RW(W-1), .PW($bits(side_h_t))) u_sqrt_h (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v4_reg), .in_rad(rad4_reg), .in_side(sh4_reg),
        .out_valid(vh), .out_root(h_q), .out_side(sh_q)
    );

    ccint_div #(.DW(W), .QW(W), .PW($bits(side_q_t))) u_div_ax (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v5_reg), .in_num({1'b0, pax5_reg}), .in_den(d5_reg), .in_side(sq5_reg),
        .out_valid(vd), .out_quot(qax), .out_side(sd_q)
    );

    ccint_div #(.DW(W), .QW(W), .PW(1)) u_div_ay (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v5_reg), .in_num({1'b0, pay5_reg}), .in_den(d5_reg), .in_side(1'b0),
        .out_valid(), .out_quot(qay), .out_side()
    );

    ccint_div #(.DW(W), .QW(W), .PW(1)) u_div_ex (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v5_reg), .in_num({1'b0, phy5_reg}), .in_den(d5_reg), .in_side(1'b0),
        .out_valid(), .out_quot(qex), .out_side()
    );

    ccint_div #(.DW(W), .QW(W), .PW(1)) u_div_ey (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v5_reg), .in_num({1'b0, phx5_reg}), .in_den(d5_reg), .in_side(1'b0),
        .out_valid(), .out_quot(qey), .out_side()
    );

    assign m_valid = v8_reg;
    assign found   = found8_reg;
    assign p1x     = p1x_reg;
    assign p1y     = p1y_reg;
    assign p2x     = p2x_reg;
    assign p2y     = p2y_reg;

endmodule

### design/circle_circle_intersection.sv
// top level of the fixed-point circle-circle intersection block
//
// usage:
//   s_ channel carries one circle pair per transfer, m_ channel one result
//   per transfer; results leave in the order the pairs came in
//   s_tdata fields (low bit up): first_center_x, first_center_y, first_radius,
//   second_center_x, second_center_y, second_radius, zero pad to whole bytes
//   m_tdata fields (low bit up): point_one_x, point_one_y, point_two_x,
//   point_two_y, zero pad; m_tuser is the found flag
// throughput: one transfer per cycle on each side, sustained while m_tready stays high
// pipeline length: set by the distance square root, the divide for a, the
//   half chord square root and the final offset divides, each one bit per
//   pipeline stage
// a front pipeline finds the centre distance and classifies the pair, a
//   four-entry queue sits between it and the back pipeline that builds the
//   points; front and back stall independently
// stall: while a result waits on a low m_tready the back freezes, the queue
//   fills, and then s_tready drops; no transfer is lost or repeated
// reset: a synchronous low on aresetn empties all stages and the queue
module circle_circle_intersection #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    // x0, y0, r0, x1, y1, r1 from the low bit up
    input  logic [((6*COORD_WIDTH-2+7)/8)*8-1:0] s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // point_one_x, point_one_y, point_two_x, point_two_y from the low bit up
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]   m_tdata,
    // found
    output logic                m_tuser,
    output logic                m_tvalid,
    input  logic                m_tready
);

    localparam int W      = COORD_WIDTH;
    localparam int OUT_TW = ((4*W+7)/8)*8;
    localparam int ENT_W  = 7*W+1;

    // unpacked input fields
    logic [W-1:0] x0, y0, x1, y1;
    logic [W-2:0] r0, r1;

    assign x0 = s_tdata[W-1:0];
    assign y0 = s_tdata[2*W-1:W];
    assign r0 = s_tdata[3*W-2:2*W];
    assign x1 = s_tdata[4*W-2:3*W-1];
    assign y1 = s_tdata[5*W-2:4*W-1];
    assign r1 = s_tdata[6*W-3:5*W-1];

    // queue handshake between front and back
    ccint_pkg::q_status_t q_status;
    logic                 push, pop;
    logic [ENT_W-1:0]     wr_entry, rd_entry;

    logic [W-1:0] p1x, p1y, p2x, p2y;

    ccint_front #(.W(W)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .x0      (x0),
        .y0      (y0),
        .r0      (r0),
        .x1      (x1),
        .y1      (y1),
        .r1      (r1),
        .q_status(q_status),
        .push    (push),
        .entry   (wr_entry)
    );

    ccint_queue #(.WIDTH(ENT_W)) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .wdata  (wr_entry),
        .pop    (pop),
        .rdata  (rd_entry),
        .status (q_status)
    );

    ccint_back #(.W(W)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_status(q_status),
        .entry   (rd_entry),
        .pop     (pop),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .found   (m_tuser),
        .p1x     (p1x),
        .p1y     (p1y),
        .p2x     (p2x),
        .p2y     (p2y)
    );

    // pack result fields, pad with zeros up to whole bytes
    assign m_tdata = OUT_TW'({p2y, p2x, p1y, p1x});

endmodule

### verif/circle_circle_intersection_tb.sv
// self-checking testbench for the circle-circle intersection block
`timescale 1ns / 1ps

module circle_circle_intersection_tb;

    localparam int CW        = 32;
    localparam int S_W       = ((6*CW-2+7)/8)*8;
    localparam int M_W       = ((4*CW+7)/8)*8;
    localparam int LATENCY   = 4*CW+11;
    localparam int CYCLE_CAP = 400000;
    localparam int N_RANDOM  = 880;

    typedef struct {
        logic signed [CW-1:0] x0, y0, x1, y1;
        logic        [CW-2:0] r0, r1;
    } circle_pair_t;

    typedef struct {
        logic                 found;
        logic signed [CW-1:0] p1x, p1y, p2x, p2y;
    } crossing_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic [S_W-1:0] s_tdata = '0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [M_W-1:0] m_tdata;
    logic           m_tuser;
    logic           m_tvalid;
    logic           m_tready = 1'b0;

    // expected crossings in arrival order
    crossing_t pending_crossings[$];
    int        mismatches = 0;
    int        pairs_sent = 0;
    int        results_seen = 0;
    int        found_seen = 0;
    int        cycles = 0;
    bit        no_idle = 1'b0;

    circle_circle_intersection #(.COORD_WIDTH(CW)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),     // x0, y0, r0, x1, y1, r1 from the low bit up
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),     // point_one_x, point_one_y, point_two_x, point_two_y
        .m_tuser  (m_tuser),     // found
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #2 aclk = ~aclk;

    // run guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_crossings.size());
            $display("FAIL");
            $finish;
        end
    end

    // floor of the square root, wide enough for a sum of two squared distances
    function automatic logic [127:0] floor_sqrt(logic [127:0] n);
        logic [127:0] root;
        logic [127:0] trial;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // truncating quotient, clamped at 2^62, zero for a zero divisor
    function automatic logic [127:0] clamped_quot(logic [127:0] n, logic [127:0] dv);
        logic [127:0] quot;
        if (dv == 0)
            return '0;
        quot = n / dv;
        return (quot >= (128'd1 << 62)) ? (128'd1 << 62) : quot;
    endfunction

    // trunc(mag * b / d) with sign of mag given separately
    function automatic logic signed [127:0] scale_by(logic [127:0] mag_a, logic neg_a,
                                                     logic signed [127:0] b,
                                                     logic [127:0] d);
        logic [127:0] mag_b;
        logic [127:0] m;
        mag_b = (b < 0) ? -b : b;
        m = clamped_quot(mag_a * mag_b, d);
        return (neg_a ^ (b < 0)) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [CW-1:0] clip_coord(logic signed [127:0] v);
        logic signed [127:0] top;
        logic signed [127:0] bottom;
        top = (128'sd1 <<< (CW-1)) - 1;
        bottom = -top - 1;
        if (v > top)
            return top[CW-1:0];
        if (v < bottom)
            return bottom[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic crossing_t predict_crossing(circle_pair_t c);
        crossing_t            res;
        logic signed [127:0]  x0, y0, x1, y1, dx, dy, px, py, ex, ey;
        logic [127:0]         adx, ady, d, r0, r1, diff, sum;
        logic [127:0]         rr, pp, qq, num, amag, aa, rad, h;
        logic                 aneg;
        res = '{1'b0, '0, '0, '0, '0};
        x0 = c.x0; y0 = c.y0; x1 = c.x1; y1 = c.y1;
        r0 = c.r0; r1 = c.r1;
        dx = x1 - x0;
        dy = y1 - y0;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        d = floor_sqrt(adx*adx + ady*ady);
        diff = (r0 > r1) ? r0 - r1 : r1 - r0;
        sum = r0 + r1;
        // shared centre, apart or nested: nothing found
        if (d == 0 || d < diff || d > sum)
            return res;
        rr = r0 * r0;
        pp = rr + d * d;
        qq = r1 * r1;
        aneg = pp < qq;
        num = aneg ? qq - pp : pp - qq;
        amag = clamped_quot(num, 2 * d);
        aa = amag * amag;
        // a negative radicand gives a zero half chord
        rad = (rr >= aa) ? rr - aa : '0;
        h = floor_sqrt(rad);
        px = x0 + scale_by(amag, aneg, dx, d);
        py = y0 + scale_by(amag, aneg, dy, d);
        ex = scale_by(h, 1'b0, dy, d);
        ey = scale_by(h, 1'b0, dx, d);
        res.found = 1'b1;
        res.p1x = clip_coord(px + ex);
        res.p1y = clip_coord(py - ey);
        res.p2x = clip_coord(px - ex);
        res.p2y = clip_coord(py + ey);
        return res;
    endfunction

    // one pair onto the s_ channel, prediction queued on the transfer edge;
    // tvalid stays up until the next falling edge so pairs can follow back to back
    task automatic send_pair(circle_pair_t c);
        @(negedge aclk);
        while (!no_idle && $urandom_range(0, 99) < 18) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        // pad bits carry noise, the block must ignore them
        s_tdata = {2'($urandom), c.r1, c.y1, c.x1, c.r0, c.y0, c.x0};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_crossings.insert(pending_crossings.size(), predict_crossing(c));
        pairs_sent++;
    endtask

    task automatic send_fields(int x0, int y0, int r0, int x1, int y1, int r1);
        circle_pair_t c;
        c.x0 = x0; c.y0 = y0; c.r0 = r0[CW-2:0];
        c.x1 = x1; c.y1 = y1; c.r1 = r1[CW-2:0];
        send_pair(c);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_crossings.size() != 0)
            @(posedge aclk);
    endtask

    // receiver back-pressure
    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= no_idle || ($urandom_range(0, 99) >= 18);
    end

    // result checker
    always @(posedge aclk) begin
        crossing_t want;
        crossing_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.found = m_tuser;
            {got.p2y, got.p2x, got.p1y, got.p1x} = m_tdata[4*CW-1:0];
            results_seen++;
            if (got.found)
                found_seen++;
            if (pending_crossings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer found=%0b", got.found);
            end else begin
                want = pending_crossings.pop_front();
                if (got.found !== want.found || got.p1x !== want.p1x ||
                    got.p1y !== want.p1y || got.p2x !== want.p2x ||
                    got.p2y !== want.p2y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: exp f=%0b %0d,%0d %0d,%0d got f=%0b %0d,%0d %0d,%0d",
                                 results_seen, want.found, want.p1x, want.p1y,
                                 want.p2x, want.p2y, got.found, got.p1x, got.p1y,
                                 got.p2x, got.p2y);
                end
            end
        end
    end

    localparam int ONE = 1 << 16;
    localparam int MAXC = 32'h7fffffff;
    localparam int MINC = 32'h80000000;
    localparam int MAXR = 32'h7fffffff;

    task automatic test_special_cases();
        send_fields(0, 0, 5*ONE, 0, 0, 3*ONE);              // shared centre
        send_fields(0, 0, ONE, 10*ONE, 0, ONE);             // apart
        send_fields(0, 0, 10*ONE, ONE, 0, 2*ONE);           // nested
        send_fields(0, 0, 2*ONE, 4*ONE, 0, 2*ONE);          // outer tangent
        send_fields(0, 0, 5*ONE, 3*ONE, 0, 2*ONE);          // inner tangent
        send_fields(0, 0, 5*ONE, 8*ONE, 0, 5*ONE);          // ordinary crossing
        send_fields(-3*ONE, 7*ONE, 4*ONE, 2*ONE, -ONE, 9*ONE);
        send_fields(0, 0, 0, 0, 0, 0);                      // zero radii
        send_fields(0, 0, 0, 1, 0, 1);                      // tiny distance
        send_fields(1, 1, 1, 2, 2, 1);
        send_fields(MAXC, MAXC, MAXR, MINC, MINC, MAXR);     // extreme corners
        send_fields(MINC, MAXC, MAXR, MAXC, MINC, MAXR);
        send_fields(MAXC, 0, MAXR, MAXC - 100*ONE, 0, MAXR); // huge radii, centres at the range edge
        send_fields(MINC, MINC, MAXR, MINC + ONE, MINC, MAXR);
        send_fields(MAXC, MAXC, MAXR, MAXC, MAXC, 0);
        send_fields(0, 0, MAXR, ONE, ONE, MAXR - ONE);      // near nested, huge radii
        send_fields(-ONE, -ONE, 3*ONE, ONE, ONE, 3*ONE);
    endtask

    // mostly crossing pairs at random scale, some raw noise
    function automatic circle_pair_t random_pair();
        circle_pair_t c;
        int           sh;
        int           span;
        if ($urandom_range(0, 9) < 2) begin
            c.x0 = $urandom; c.y0 = $urandom; c.x1 = $urandom; c.y1 = $urandom;
            c.r0 = (CW-1)'($urandom); c.r1 = (CW-1)'($urandom);
            return c;
        end
        sh = $urandom_range(0, 29);
        c.r0 = (CW-1)'($urandom >> (2 + sh));
        c.r1 = (CW-1)'($urandom >> (2 + sh));
        span = (int'(c.r0) + int'(c.r1)) / 2 + 1;
        c.x0 = $urandom >> (1 + $urandom_range(0, 30));
        if ($urandom_range(0, 1)) c.x0 = -c.x0;
        c.y0 = $urandom >> (1 + $urandom_range(0, 30));
        if ($urandom_range(0, 1)) c.y0 = -c.y0;
        c.x1 = c.x0 + $signed($urandom_range(0, 2*span)) - span;
        c.y1 = c.y0 + $signed($urandom_range(0, 2*span)) - span;
        return c;
    endfunction

    task automatic test_random_stream(int count);
        for (int i = 0; i < count; i++) begin
            // a stretch with no idling on either side
            no_idle = (i >= count/3) && (i < count/3 + 150);
            send_pair(random_pair());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++)
            send_pair(random_pair());
        // sender holds off until the pipeline has emptied
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_pair(random_pair());
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_special_cases();
        test_drain_pause();
        test_random_stream(N_RANDOM);

        wait_drained();
        repeat (2*LATENCY) @(posedge aclk);

        $display("covered %0d circle pairs: %0d results, %0d with crossings",
                 pairs_sent, results_seen, found_seen);
        $display("special cases, range extremes, saturation, drain pause, back-pressure");
        if (mismatches == 0 && pending_crossings.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_crossings.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
